>>> hdl/utf8d_pkg.sv
// Shared types and constants for the UTF-8 to UTF-16 validating decoder.
// No dependencies; imported by every module of the block.
`default_nettype none

package utf8d_pkg;

    localparam int unsigned MAX_BYTES = 1024;
    // byte counter saturates at MAX_BYTES + 1
    localparam int unsigned TOTAL_W   = $clog2(MAX_BYTES + 2);

    localparam logic [20:0] MIN_2BYTE   = 21'h00080;
    localparam logic [20:0] MIN_3BYTE   = 21'h00800;
    localparam logic [20:0] MIN_4BYTE   = 21'h10000;
    localparam logic [20:0] MAX_SCALAR  = 21'h10FFFF;
    localparam logic [20:0] SURR_LO     = 21'h0D800;
    localparam logic [20:0] SURR_HI     = 21'h0DFFF;
    localparam logic [20:0] BMP_MAX     = 21'h0FFFF;
    localparam logic [20:0] HIGH_SURR   = 21'h0D800;
    localparam logic [20:0] LOW_SURR    = 21'h0DC00;

    typedef enum logic [2:0] {
        ST_OK         = 3'd0,
        ST_BAD_LEAD   = 3'd1,
        ST_BAD_CONT   = 3'd2,
        ST_TRUNCATED  = 3'd3,
        ST_BAD_SCALAR = 3'd4,
        ST_TOO_LONG   = 3'd5
    } status_t;

    typedef struct packed {
        logic [7:0] in_byte;
        logic       final_byte;
    } src_t;

    typedef struct packed {
        logic [20:0] code_unit;
        logic        unit_valid;
        status_t     status;
        logic        end_of_run;
    } res_t;

    // up to two result words produced by one byte
    typedef struct packed {
        logic [1:0] count;
        res_t       item0;
        res_t       item1;
    } bundle_t;

endpackage

`default_nettype wire

>>> hdl/utf8d_core.sv
// Per-byte decode: sequence state, validation and unit generation.
// Depends on utf8d_pkg; feeds utf8d_obuf with one bundle per accepted byte.
`default_nettype none

module utf8d_core (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              wr_en,
    input  wire logic              wr_data,
    input  wire logic              accept,
    input  wire utf8d_pkg::src_t   src_data,
    output utf8d_pkg::bundle_t     bundle
);
    import utf8d_pkg::*;

    localparam logic [TOTAL_W-1:0] MAX_T = TOTAL_W'(MAX_BYTES);

    logic                wide_reg;
    logic [20:0]         accum_reg,    accum_next;
    logic [1:0]          expect_reg,   expect_next;
    logic [1:0]          tail_reg,     tail_next;
    logic [TOTAL_W-1:0]  total_reg,    total_next;
    status_t             err_reg,      err_next;
    logic                open_reg,     open_next;

    logic [7:0]  b;
    logic        fin_go;
    logic        fin_flag;
    logic [20:0] fin_s;
    logic [1:0]  fin_tail;
    logic        bad_scalar;
    logic [20:0] acc_sh;
    logic [19:0] v;
    logic [20:0] u0;
    logic [20:0] u1;
    logic [1:0]  nu;
    status_t     fin_status;

    assign b = src_data.in_byte;

    always_comb
    begin
        total_next  = (total_reg <= MAX_T) ? total_reg + 1'b1 : total_reg;
        accum_next  = accum_reg;
        expect_next = expect_reg;
        tail_next   = tail_reg;
        err_next    = err_reg;
        open_next   = open_reg;
        fin_go      = 1'b0;
        fin_flag    = open_reg;
        fin_s       = '0;
        fin_tail    = '0;
        acc_sh      = {accum_reg[14:0], b[5:0]};

        if (expect_reg == 2'd0)
        begin
            priority if (b != 8'h00 && !b[7])
            begin
                fin_go = 1'b1;
                fin_s  = {13'd0, b};
            end
            else if (b >= 8'hC2 && b <= 8'hDF)
            begin
                accum_next  = {16'd0, b[4:0]};
                expect_next = 2'd1;
                tail_next   = 2'd1;
            end
            else if (b >= 8'hE0 && b <= 8'hEF)
            begin
                accum_next  = {17'd0, b[3:0]};
                expect_next = 2'd2;
                tail_next   = 2'd2;
            end
            else if (b >= 8'hF0 && b <= 8'hF4)
            begin
                accum_next  = {18'd0, b[2:0]};
                expect_next = 2'd3;
                tail_next   = 2'd3;
            end
            else
            begin
                if (err_reg == ST_OK)
                    err_next = ST_BAD_LEAD;
            end
        end
        else
        begin
            // position decides length; a bad tail byte is only flagged
            open_next   = open_reg | (b[7:6] != 2'b10);
            accum_next  = acc_sh;
            expect_next = expect_reg - 2'd1;
            if (expect_next == 2'd0)
            begin
                fin_go     = 1'b1;
                fin_s      = acc_sh;
                fin_tail   = tail_reg;
                fin_flag   = open_next;
                accum_next = '0;
                tail_next  = '0;
            end
        end

        bad_scalar = (fin_tail == 2'd1 && fin_s < MIN_2BYTE)
                  || (fin_tail == 2'd2 && fin_s < MIN_3BYTE)
                  || (fin_tail == 2'd3 && fin_s < MIN_4BYTE)
                  || (fin_s > MAX_SCALAR)
                  || (fin_s >= SURR_LO && fin_s <= SURR_HI);

        v  = 20'(fin_s - MIN_4BYTE);
        u0 = fin_s;
        u1 = '0;
        nu = 2'd0;

        if (fin_go)
        begin
            priority if (fin_flag)
            begin
                open_next = 1'b0;
                if (err_next == ST_OK)
                    err_next = ST_BAD_CONT;
            end
            else if (bad_scalar)
            begin
                if (err_next == ST_OK)
                    err_next = ST_BAD_SCALAR;
            end
            else if (err_reg != ST_OK || total_next > MAX_T)
            begin
                nu = 2'd0;
            end
            else if (!wide_reg && fin_s > BMP_MAX)
            begin
                u0 = HIGH_SURR + {11'd0, v[19:10]};
                u1 = LOW_SURR + {11'd0, v[9:0]};
                nu = 2'd2;
            end
            else
            begin
                nu = 2'd1;
            end
        end

        priority if (total_next > MAX_T)
            fin_status = ST_TOO_LONG;
        else if (err_next != ST_OK)
            fin_status = err_next;
        else if (expect_next != 2'd0)
            fin_status = ST_TRUNCATED;
        else
            fin_status = ST_OK;

        bundle.item0.code_unit  = u0;
        bundle.item0.unit_valid = 1'b1;
        bundle.item0.status     = ST_OK;
        bundle.item0.end_of_run = 1'b0;
        bundle.item1.code_unit  = u1;
        bundle.item1.unit_valid = 1'b1;
        bundle.item1.status     = ST_OK;
        bundle.item1.end_of_run = 1'b0;
        bundle.count            = nu;

        if (src_data.final_byte)
        begin
            if (nu == 2'd0)
            begin
                bundle.count            = 2'd1;
                bundle.item0.code_unit  = '0;
                bundle.item0.unit_valid = 1'b0;
            end
            if (nu == 2'd2)
            begin
                bundle.item1.status     = fin_status;
                bundle.item1.end_of_run = 1'b1;
            end
            else
            begin
                bundle.item0.status     = fin_status;
                bundle.item0.end_of_run = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            wide_reg <= 1'b0;
        else if (wr_en)
            wide_reg <= wr_data;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            accum_reg  <= '0;
            expect_reg <= '0;
            tail_reg   <= '0;
            total_reg  <= '0;
            err_reg    <= ST_OK;
            open_reg   <= 1'b0;
        end
        else if (accept)
        begin
            if (src_data.final_byte)
            begin
                accum_reg  <= '0;
                expect_reg <= '0;
                tail_reg   <= '0;
                total_reg  <= '0;
                err_reg    <= ST_OK;
                open_reg   <= 1'b0;
            end
            else
            begin
                accum_reg  <= accum_next;
                expect_reg <= expect_next;
                tail_reg   <= tail_next;
                total_reg  <= total_next;
                err_reg    <= err_next;
                open_reg   <= open_next;
            end
        end
    end

endmodule

`default_nettype wire

>>> hdl/utf8d_obuf.sv
// Two-entry result buffer: holds one byte's words, drains one a cycle on res_ready.
// Depends on utf8d_pkg; loaded by utf8d_core bundles.
`default_nettype none

module utf8d_obuf (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 load,
    input  wire utf8d_pkg::bundle_t   bundle,
    output logic                      src_ready,
    output logic                      res_valid,
    input  wire logic                 res_ready,
    output utf8d_pkg::res_t           res_data
);
    import utf8d_pkg::*;

    logic [1:0] cnt_reg, cnt_next;
    res_t       slot0_reg;
    res_t       slot1_reg;
    logic       pop;

    assign res_valid = (cnt_reg != 2'd0);
    assign res_data  = slot0_reg;
    assign pop       = res_valid && res_ready;
    // room for a new bundle once the buffer is empty or empties this cycle
    assign src_ready = (cnt_reg == 2'd0) || (cnt_reg == 2'd1 && res_ready);

    always_comb
    begin
        if (load)
            cnt_next = bundle.count;
        else if (pop)
            cnt_next = cnt_reg - 2'd1;
        else
            cnt_next = cnt_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            cnt_reg <= '0;
        else
            cnt_reg <= cnt_next;
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            slot0_reg <= bundle.item0;
            slot1_reg <= bundle.item1;
        end
        else if (pop)
        begin
            slot0_reg <= slot1_reg;
        end
    end

endmodule

`default_nettype wire

>>> hdl/utf8_to_utf16_validating_decoder.sv
// Top level of the UTF-8 to UTF-16 validating decoder.
// Depends on utf8d_pkg, utf8d_core and utf8d_obuf.
//
//  channel | direction | handshake              | word
//  --------+-----------+------------------------+------------------------------
//  src     | in        | src_valid / src_ready  | in_byte, final_byte
//  res     | out       | res_valid / res_ready  | code_unit, unit_valid, status,
//          |           |                        | end_of_run
//  cfg     | in        | wr_en (no wait)        | wr_data = wide_output
//
// One byte is accepted per cycle while src_ready is high; its result words appear
// in the next cycle. A byte that completes a surrogate pair yields two words, which
// the two-entry buffer drains one per cycle while res_ready is high, so src_ready
// drops. Reset needs no clearing pass. src_ready is high only when the buffer
// is empty or its last word leaves this cycle, so a stalled res side holds it low.
`default_nettype none

module utf8_to_utf16_validating_decoder (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               wr_en,
    input  wire logic               wr_data,
    input  wire logic               src_valid,
    output logic                    src_ready,
    input  wire utf8d_pkg::src_t    src_data,
    output logic                    res_valid,
    input  wire logic               res_ready,
    output utf8d_pkg::res_t         res_data
);
    import utf8d_pkg::*;

    logic    accept;
    bundle_t bundle;

    assign accept = src_valid && src_ready;

    utf8d_core u_core (
        .clk      (clk),
        .rst_n    (rst_n),
        .wr_en    (wr_en),
        .wr_data  (wr_data),
        .accept   (accept),
        .src_data (src_data),
        .bundle   (bundle)
    );

    utf8d_obuf u_obuf (
        .clk       (clk),
        .rst_n     (rst_n),
        .load      (accept),
        .bundle    (bundle),
        .src_ready (src_ready),
        .res_valid (res_valid),
        .res_ready (res_ready),
        .res_data  (res_data)
    );

endmodule

`default_nettype wire
